// File: hw/rtl/dncu_pkg.sv
package dncu_pkg;

    // calendar range
    localparam int MAX_YEAR    = 9999;
    localparam int BASE_YEAR   = 1901;
    localparam int BASE_N      = BASE_YEAR - 1;
    // days in years 1 .. BASE_YEAR-1, and last day number of MAX_YEAR
    localparam int BASE_DAYS   = 365 * BASE_N + BASE_N / 4 - BASE_N / 100 + BASE_N / 400;
    localparam int LAST_DAY    = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                 + MAX_YEAR / 400 - BASE_DAYS;
    localparam int BASE_MOD400 = BASE_YEAR % 400;

    // block lengths used by the year walk
    localparam int DAYS_400 = 146097;
    localparam int DAYS_4   = 1461;
    localparam int DAYS_1   = 365;

    // reciprocal constants for division by 100 and by 7
    localparam int RECIP_100_SHIFT = 19;
    localparam int RECIP_100       = (2 ** RECIP_100_SHIFT + 99) / 100;
    localparam int RECIP_7_SHIFT   = 25;
    localparam int RECIP_7         = (2 ** RECIP_7_SHIFT + 6) / 7;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int CNT_W   = 22;
    localparam int OFF_W   = 23;
    localparam int WDAY_W  = 3;
    localparam int M400_W  = 9;
    localparam int LEN_W   = 18;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [DAY_W-1:0]        load_day;
        logic [MON_W-1:0]        load_month;
        logic [YEAR_W-1:0]       load_year;
        logic signed [OFF_W-1:0] offset;
    } req_t;

    typedef struct packed {
        logic [DAY_W-1:0]  day_of_month;
        logic [MON_W-1:0]  month_now;
        logic [YEAR_W-1:0] year_now;
        logic [CNT_W-1:0]  day_count;
        logic [WDAY_W-1:0] weekday;
        logic              date_valid;
        logic              refused;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // length of month m, with february stretched in a leap year
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [MON_W-1:0] idx;
        logic [DAY_W-1:0] len;
        idx = m - 4'd1;
        if (idx > 4'd11) begin
            len = 5'd31;
        end else begin
            len = MONTH_LEN[idx];
        end
        if (m == 4'd2 && leap) begin
            len = 5'd29;
        end
        return len;
    endfunction

    // leap test from the year's residue modulo 400
    function automatic logic leap_of_m400(input logic [M400_W-1:0] m400);
        return (m400 == 9'd0) ||
               ((m400[1:0] == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200) &&
                (m400 != 9'd300));
    endfunction

endpackage

// File: hw/rtl/day_number_calendar_unit.sv
// Calendar date unit: holds one Gregorian date as a day number, day 1 being
// 1 January 1901 and 0 meaning no date is held.
// Input stream (s_): one request per transfer. s_tuser selects the kind:
// 0 loads day, month and year from s_tdata, 1 adds the signed offset in
// s_tdata to the held date. Every request returns exactly one result on the
// m_ stream with the date held afterwards, its weekday (1 Sunday .. 7
// Saturday), a valid flag and a refused flag.
// A load divides the year by 100, checks range and leap year, sums the whole
// years, then adds the months before the loaded month and the day; the
// weekday follows. An add walks the years in 400-year, 4-year and 1-year
// steps and then the months on one shared subtractor; an add with no date
// held goes straight to the weekday. One request is worked on at a time:
// s_tready is high only while the sequencer is idle, so a new one waits.
// The result sits in an output register; while the receiver stalls the
// sequencer waits with the next result, and s_tready rises again as soon as
// the waiting result has moved into the output register.
// Reset (aresetn low, synchronous) clears the held date to no date and drops
// m_tvalid.
module day_number_calendar_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // load_day[4:0], load_month[8:5], load_year[22:9], offset[45:23], zero pad
    input  logic [dncu_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  logic [dncu_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // day_of_month[4:0], month_now[8:5], year_now[22:9], day_count[44:23],
    // weekday[47:45]
    output logic [dncu_pkg::M_TDATA_W-1:0] m_tdata,
    // date_valid[0], refused[1]
    output logic [dncu_pkg::M_TUSER_W-1:0] m_tuser
);
    import dncu_pkg::*;

    req_t       req;
    res_t       res;
    core_stat_t stat;
    logic       res_take;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // unpack request
    assign req.kind       = s_tuser[0];
    assign req.load_day   = s_tdata[4:0];
    assign req.load_month = s_tdata[8:5];
    assign req.load_year  = s_tdata[22:9];
    assign req.offset     = $signed(s_tdata[45:23]);

    assign s_tready = stat.idle;

    dncu_core u_core (
        .clk      (aclk),
        .rst_n    (aresetn),
        .start    (s_tvalid && s_tready),
        .req      (req),
        .res_take (res_take),
        .stat     (stat),
        .res      (res)
    );

    // output register, loaded when empty or being drained
    assign res_take = stat.done && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res.weekday, res.day_count, res.year_now, res.month_now,
                             res.day_of_month};
            m_tuser_next  = {res.refused, res.date_valid};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hw/rtl/dncu_core.sv
module dncu_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dncu_pkg::req_t      req,
    input  logic                res_take,
    output dncu_pkg::core_stat_t stat,
    output dncu_pkg::res_t      res
);
    import dncu_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_LD_DIV  = 13'b0000000000010,
        ST_LD_CHK  = 13'b0000000000100,
        ST_LD_SUM  = 13'b0000000001000,
        ST_LD_MON  = 13'b0000000010000,
        ST_ADD_CHK = 13'b0000000100000,
        ST_Y400    = 13'b0000001000000,
        ST_Y4      = 13'b0000010000000,
        ST_Y1      = 13'b0000100000000,
        ST_MON     = 13'b0001000000000,
        ST_WK_DIV  = 13'b0010000000000,
        ST_WK_MOD  = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        held_count_reg, held_count_next;
    logic [DAY_W-1:0]        held_day_reg, held_day_next;
    logic [MON_W-1:0]        held_month_reg, held_month_next;
    logic [YEAR_W-1:0]       held_year_reg, held_year_next;
    logic                    refused_reg, refused_next;
    logic [DAY_W-1:0]        ld_day_reg, ld_day_next;
    logic [MON_W-1:0]        ld_month_reg, ld_month_next;
    logic [YEAR_W-1:0]       ld_year_reg, ld_year_next;
    logic signed [OFF_W-1:0] off_reg, off_next;
    logic [7:0]              qy_reg, qy_next;
    logic [7:0]              n100_reg, n100_next;
    logic [22:0]             prod_reg, prod_next;
    logic                    leap_reg, leap_next;
    logic [CNT_W-1:0]        acc_reg, acc_next;
    logic [MON_W-1:0]        mon_reg, mon_next;
    logic [YEAR_W-1:0]       yr_reg, yr_next;
    logic [M400_W-1:0]       m400_reg, m400_next;
    logic [18:0]             wq_reg, wq_next;
    logic [WDAY_W-1:0]       wday_reg, wday_next;

    // shared add / subtract unit on the accumulator
    logic              au_sub;
    logic [LEN_W-1:0]  au_opd;
    logic [CNT_W:0]    au_sum;
    logic              au_gt;

    // helper terms
    logic [26:0]       qy_prod;
    logic [YEAR_W-1:0] ld_year_m1;
    logic [YEAR_W-1:0] r100_full;
    logic [6:0]        r100;
    logic              ld_leap;
    logic              ld_ok;
    logic [23:0]       base_sum;
    logic signed [24:0] add_sum;
    logic              add_bad;
    logic [DAY_W-1:0]  mdays;
    logic [1:0]        d4;
    logic [9:0]        m400_lp;
    logic              cent_skip;
    logic [LEN_W-1:0]  len4;
    logic              cur_leap;
    logic [LEN_W-1:0]  len1;
    logic [9:0]        m400_p4;
    logic [9:0]        m400_p1;
    logic [44:0]       wprod;
    logic [CNT_W-1:0]  wr_full;
    logic [2:0]        wr;

    // datapath terms
    always_comb begin
        qy_prod    = 27'(ld_year_reg) * 27'(RECIP_100);
        ld_year_m1 = ld_year_reg - 14'd1;
        r100_full  = ld_year_reg - 14'(14'(qy_reg) * 14'd100);
        r100       = r100_full[6:0];
        ld_leap    = (r100 == 7'd0) ? (qy_reg[1:0] == 2'd0) : (ld_year_reg[1:0] == 2'd0);
        ld_ok      = (ld_year_reg >= 14'(BASE_YEAR)) && (ld_year_reg <= 14'(MAX_YEAR)) &&
                     (ld_month_reg >= 4'd1) && (ld_month_reg <= 4'd12) &&
                     (ld_day_reg != 5'd0) &&
                     (ld_day_reg <= month_days(ld_month_reg, ld_leap));
        base_sum   = 24'(prod_reg) + 24'(ld_year_m1 >> 2) + 24'(n100_reg >> 2)
                     - 24'(n100_reg) - 24'(BASE_DAYS);
        add_sum    = $signed({3'b000, held_count_reg}) +
                     $signed({{2{off_reg[OFF_W-1]}}, off_reg});
        add_bad    = (add_sum <= 25'sd0) || (add_sum > $signed(25'(LAST_DAY)));
        mdays      = month_days(mon_reg, leap_reg);
        // next multiple-of-4 year inside the four-year block
        d4         = 2'(3'd4 - {1'b0, m400_reg[1:0]});
        m400_lp    = 10'(m400_reg) + 10'(d4);
        cent_skip  = (m400_lp == 10'd100) || (m400_lp == 10'd200) || (m400_lp == 10'd300);
        len4       = 18'(DAYS_4) - 18'(cent_skip);
        cur_leap   = leap_of_m400(m400_reg);
        len1       = 18'(DAYS_1) + 18'(cur_leap);
        m400_p4    = 10'(m400_reg) + 10'd4;
        m400_p1    = 10'(m400_reg) + 10'd1;
        wprod      = 45'(held_count_reg) * 45'(RECIP_7);
        wr_full    = held_count_reg - 22'(22'(wq_reg) * 22'd7);
        wr         = wr_full[2:0];
    end

    // operand select for the shared unit
    always_comb begin
        au_sub = 1'b1;
        au_opd = '0;
        unique case (state_reg)
            ST_LD_MON: begin
                au_sub = 1'b0;
                au_opd = (mon_reg < ld_month_reg) ? 18'(mdays) : 18'(ld_day_reg);
            end
            ST_Y400: au_opd = 18'(DAYS_400);
            ST_Y4:   au_opd = len4;
            ST_Y1:   au_opd = len1;
            ST_MON:  au_opd = 18'(mdays);
            default: au_opd = '0;
        endcase
        au_sum = au_sub ? ({1'b0, acc_reg} - 23'(au_opd)) : ({1'b0, acc_reg} + 23'(au_opd));
        au_gt  = !au_sum[CNT_W] && (au_sum[CNT_W-1:0] != '0);
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        held_day_next   = held_day_reg;
        held_month_next = held_month_reg;
        held_year_next  = held_year_reg;
        refused_next    = refused_reg;
        ld_day_next     = ld_day_reg;
        ld_month_next   = ld_month_reg;
        ld_year_next    = ld_year_reg;
        off_next        = off_reg;
        qy_next         = qy_reg;
        n100_next       = n100_reg;
        prod_next       = prod_reg;
        leap_next       = leap_reg;
        acc_next        = acc_reg;
        mon_next        = mon_reg;
        yr_next         = yr_reg;
        m400_next       = m400_reg;
        wq_next         = wq_reg;
        wday_next       = wday_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ld_day_next   = req.load_day;
                    ld_month_next = req.load_month;
                    ld_year_next  = req.load_year;
                    off_next      = req.offset;
                    refused_next  = 1'b0;
                    if (req.kind == KIND_LOAD) begin
                        state_next = ST_LD_DIV;
                    end else if (held_count_reg == '0) begin
                        state_next = ST_WK_DIV;
                    end else begin
                        state_next = ST_ADD_CHK;
                    end
                end
            end
            // year divided by 100
            ST_LD_DIV: begin
                qy_next    = 8'(qy_prod >> RECIP_100_SHIFT);
                state_next = ST_LD_CHK;
            end
            // range check and leap year of the load
            ST_LD_CHK: begin
                if (ld_ok) begin
                    leap_next  = ld_leap;
                    n100_next  = qy_reg - 8'(r100 == 7'd0);
                    prod_next  = 23'(ld_year_m1) * 23'(DAYS_1);
                    state_next = ST_LD_SUM;
                end else begin
                    held_count_next = '0;
                    held_day_next   = '0;
                    held_month_next = '0;
                    held_year_next  = '0;
                    refused_next    = 1'b1;
                    state_next      = ST_WK_DIV;
                end
            end
            // days in whole years before the loaded year
            ST_LD_SUM: begin
                acc_next   = base_sum[CNT_W-1:0];
                mon_next   = 4'd1;
                state_next = ST_LD_MON;
            end
            // add whole months, then the day
            ST_LD_MON: begin
                acc_next = au_sum[CNT_W-1:0];
                if (mon_reg < ld_month_reg) begin
                    mon_next = mon_reg + 4'd1;
                end else begin
                    held_count_next = au_sum[CNT_W-1:0];
                    held_day_next   = ld_day_reg;
                    held_month_next = ld_month_reg;
                    held_year_next  = ld_year_reg;
                    state_next      = ST_WK_DIV;
                end
            end
            ST_ADD_CHK: begin
                if (add_bad) begin
                    refused_next = 1'b1;
                    state_next   = ST_WK_DIV;
                end else begin
                    held_count_next = add_sum[CNT_W-1:0];
                    acc_next        = add_sum[CNT_W-1:0];
                    yr_next         = 14'(BASE_YEAR);
                    m400_next       = 9'(BASE_MOD400);
                    state_next      = ST_Y400;
                end
            end
            // walk 400-year blocks
            ST_Y400: begin
                if (au_gt) begin
                    acc_next = au_sum[CNT_W-1:0];
                    yr_next  = yr_reg + 14'd400;
                end else begin
                    state_next = ST_Y4;
                end
            end
            // walk 4-year blocks
            ST_Y4: begin
                if (au_gt) begin
                    acc_next  = au_sum[CNT_W-1:0];
                    yr_next   = yr_reg + 14'd4;
                    m400_next = (m400_p4 >= 10'd400) ? 9'(m400_p4 - 10'd400) : 9'(m400_p4);
                end else begin
                    state_next = ST_Y1;
                end
            end
            // walk single years
            ST_Y1: begin
                if (au_gt) begin
                    acc_next  = au_sum[CNT_W-1:0];
                    yr_next   = yr_reg + 14'd1;
                    m400_next = (m400_p1 >= 10'd400) ? 9'(m400_p1 - 10'd400) : 9'(m400_p1);
                end else begin
                    leap_next  = cur_leap;
                    mon_next   = 4'd1;
                    state_next = ST_MON;
                end
            end
            // walk months
            ST_MON: begin
                if (au_gt && (mon_reg < 4'd12)) begin
                    acc_next = au_sum[CNT_W-1:0];
                    mon_next = mon_reg + 4'd1;
                end else begin
                    held_day_next   = acc_reg[DAY_W-1:0];
                    held_month_next = mon_reg;
                    held_year_next  = yr_reg;
                    state_next      = ST_WK_DIV;
                end
            end
            // day count divided by 7
            ST_WK_DIV: begin
                wq_next    = 19'(wprod >> RECIP_7_SHIFT);
                state_next = ST_WK_MOD;
            end
            // weekday from remainder, day 1 is a tuesday
            ST_WK_MOD: begin
                if (held_count_reg == '0) begin
                    wday_next = 3'd0;
                end else begin
                    unique case (wr)
                        3'd5:    wday_next = 3'd7;
                        3'd6:    wday_next = 3'd1;
                        default: wday_next = wr + 3'd2;
                    endcase
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and held date
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            held_day_reg   <= '0;
            held_month_reg <= '0;
            held_year_reg  <= '0;
            refused_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            held_day_reg   <= held_day_next;
            held_month_reg <= held_month_next;
            held_year_reg  <= held_year_next;
            refused_reg    <= refused_next;
        end
    end

    // working registers
    always_ff @(posedge clk) begin
        ld_day_reg   <= ld_day_next;
        ld_month_reg <= ld_month_next;
        ld_year_reg  <= ld_year_next;
        off_reg      <= off_next;
        qy_reg       <= qy_next;
        n100_reg     <= n100_next;
        prod_reg     <= prod_next;
        leap_reg     <= leap_next;
        acc_reg      <= acc_next;
        mon_reg      <= mon_next;
        yr_reg       <= yr_next;
        m400_reg     <= m400_next;
        wq_reg       <= wq_next;
        wday_reg     <= wday_next;
    end

    // status and result
    assign stat.idle        = (state_reg == ST_IDLE);
    assign stat.done        = (state_reg == ST_DONE);
    assign res.day_of_month = held_day_reg;
    assign res.month_now    = held_month_reg;
    assign res.year_now     = held_year_reg;
    assign res.day_count    = held_count_reg;
    assign res.weekday      = wday_reg;
    assign res.date_valid   = (held_count_reg != '0);
    assign res.refused      = refused_reg;

endmodule

// File: hw/rtl/dncu_checker.sv
module dncu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [dncu_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [dncu_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dncu_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dncu_pkg::M_TUSER_W-1:0] m_tuser
);
    import dncu_pkg::*;

    logic s_seen;
    assign s_seen = (s_tdata != '0) || (s_tuser != '0) || 1'b1;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_seen |=> !s_tready)
        else $error("request taken while previous one in progress");

    // no date held means every date field is zero
    a_no_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("date fields set with no date held");

    // a held date is well formed and in range
    a_date_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[47:45] != 3'd0) && (m_tdata[8:5] >= 4'd1) && (m_tdata[8:5] <= 4'd12) &&
            (m_tdata[4:0] != 5'd0) && (m_tdata[44:23] <= 22'(LAST_DAY)) &&
            (m_tdata[22:9] >= 14'(BASE_YEAR)) && (m_tdata[22:9] <= 14'(MAX_YEAR)))
        else $error("held date out of range");

endmodule

bind day_number_calendar_unit dncu_checker u_dncu_checker (.*);
